// ===== sv/bmav_pkg.sv =====
// ----------------------------------------------------------------------------
// bmav_pkg: shared definitions for the bracket-matched argument validator
// Token kind codes, reason codes, closer codes and the argument-list state.
// ----------------------------------------------------------------------------
package bmav_pkg;

  localparam int MaxNesting = 32;
  localparam int DepthW     = $clog2(MaxNesting + 1);
  localparam int IdxW       = $clog2(MaxNesting);

  // token kinds
  localparam logic [3:0] KindOther   = 4'd0;
  localparam logic [3:0] KindSpace   = 4'd1;
  localparam logic [3:0] KindEof     = 4'd2;
  localparam logic [3:0] KindComma   = 4'd3;
  localparam logic [3:0] KindSemi    = 4'd4;
  localparam logic [3:0] KindBang    = 4'd5;
  localparam logic [3:0] KindFunc    = 4'd6;
  localparam logic [3:0] KindLParen  = 4'd7;
  localparam logic [3:0] KindLSquare = 4'd8;
  localparam logic [3:0] KindLCurly  = 4'd9;
  localparam logic [3:0] KindRParen  = 4'd10;
  localparam logic [3:0] KindRSquare = 4'd11;
  localparam logic [3:0] KindRCurly  = 4'd12;

  // expected closers held on the stack
  localparam logic [1:0] ClParen  = 2'd0;
  localparam logic [1:0] ClSquare = 2'd1;
  localparam logic [1:0] ClCurly  = 2'd2;

  // verdict reasons
  localparam logic [2:0] RsnOk        = 3'd0;
  localparam logic [2:0] RsnUnmatched = 3'd1;
  localparam logic [2:0] RsnSemicolon = 3'd2;
  localparam logic [2:0] RsnBang      = 3'd3;
  localparam logic [2:0] RsnFewArgs   = 3'd4;
  localparam logic [2:0] RsnEmptyKey  = 3'd5;
  localparam logic [2:0] RsnMixed     = 3'd6;
  localparam logic [2:0] RsnTooDeep   = 3'd7;

  // item flag bits
  localparam int FlAny   = 0;
  localparam int FlBlock = 1;
  localparam int FlOther = 2;

  typedef struct packed {
    logic [DepthW-1:0] depth;
    logic              arg_many;   // a top-level comma was seen
    logic              key_blank;
    logic              mixed;
    logic [2:0]        flags;
  } list_state_t;

  localparam list_state_t StateReset = '{
    depth:     '0,
    arg_many:  1'b0,
    key_blank: 1'b1,
    mixed:     1'b0,
    flags:     3'b000
  };

  typedef struct packed {
    logic       emit;
    logic       ok;
    logic [2:0] reason;
  } verdict_t;

  typedef struct packed {
    logic       en;
    logic [1:0] code;
  } push_t;

endpackage

// ===== sv/bmav_core.sv =====
// ----------------------------------------------------------------------------
// bmav_core: per-token grammar step
// Decodes one token against the current list state, gives the next state,
// the stack push and the verdict when the list ends or fails.
// ----------------------------------------------------------------------------
module bmav_core (
  input  logic [3:0]           kind_i,
  input  logic                 last_i,
  input  bmav_pkg::list_state_t st_i,
  input  logic [1:0]           top_i,      // closer on top of the stack
  input  logic [1:0]           bottom_i,   // closer at stack entry zero
  output bmav_pkg::list_state_t st_o,
  output bmav_pkg::push_t      push_o,
  output bmav_pkg::verdict_t   verdict_o
);

  logic [3:0]            k;
  logic                  lvl0;
  logic                  fail;
  logic [2:0]            fail_rsn;
  logic                  fin;
  logic [1:0]            code;
  bmav_pkg::list_state_t n;
  logic [2:0]            fin_flags;
  logic                  fin_key_blank;
  logic [1:0]            bottom_eff;

  always_comb begin
    k        = (kind_i > bmav_pkg::KindRCurly) ? bmav_pkg::KindOther : kind_i;
    lvl0     = (st_i.depth == '0);
    n        = st_i;
    fail     = 1'b0;
    fail_rsn = bmav_pkg::RsnOk;
    fin      = 1'b0;
    code     = 2'(k - bmav_pkg::KindRParen);
    push_o   = '{en: 1'b0, code: bmav_pkg::ClParen};

    if (k == bmav_pkg::KindEof) begin
      fin = 1'b1;
    end else if (k == bmav_pkg::KindSpace) begin
      fin = 1'b0;
    end else if (k >= bmav_pkg::KindRParen) begin
      if (lvl0) begin
        if (code == bmav_pkg::ClParen) begin
          fin = 1'b1;
        end else begin
          fail     = 1'b1;
          fail_rsn = bmav_pkg::RsnUnmatched;
        end
      end else if (top_i != code) begin
        fail     = 1'b1;
        fail_rsn = bmav_pkg::RsnUnmatched;
      end else begin
        n.depth = st_i.depth - 1'b1;
        if (n.depth == '0 && code == bmav_pkg::ClCurly) begin
          n.flags[bmav_pkg::FlBlock] = 1'b1;
        end
      end
    end else if (lvl0 && k == bmav_pkg::KindComma) begin
      if (!st_i.arg_many) begin
        n.key_blank = ~st_i.flags[bmav_pkg::FlAny];
      end
      n.mixed    = st_i.mixed |
                   (st_i.flags[bmav_pkg::FlBlock] & st_i.flags[bmav_pkg::FlOther]);
      n.arg_many = 1'b1;
      n.flags    = 3'b000;
    end else if (lvl0 && k == bmav_pkg::KindSemi) begin
      fail     = 1'b1;
      fail_rsn = bmav_pkg::RsnSemicolon;
    end else if (lvl0 && k == bmav_pkg::KindBang) begin
      fail     = 1'b1;
      fail_rsn = bmav_pkg::RsnBang;
    end else begin
      if (lvl0) begin
        n.flags[bmav_pkg::FlAny] = 1'b1;
        if (k != bmav_pkg::KindLCurly) begin
          n.flags[bmav_pkg::FlOther] = 1'b1;
        end
      end
      if (k >= bmav_pkg::KindFunc && k <= bmav_pkg::KindLCurly) begin
        if (st_i.depth >= bmav_pkg::DepthW'(bmav_pkg::MaxNesting)) begin
          fail     = 1'b1;
          fail_rsn = bmav_pkg::RsnTooDeep;
        end else begin
          push_o.en   = 1'b1;
          push_o.code = (k == bmav_pkg::KindLSquare) ? bmav_pkg::ClSquare :
                        (k == bmav_pkg::KindLCurly)  ? bmav_pkg::ClCurly  :
                                                       bmav_pkg::ClParen;
          n.depth     = st_i.depth + 1'b1;
        end
      end
    end

    if (!fail && last_i) begin
      fin = 1'b1;
    end

    // close-out evaluated on the state after this token
    bottom_eff = (push_o.en && lvl0) ? push_o.code : bottom_i;
    fin_flags  = n.flags;
    if (n.depth != '0 && bottom_eff == bmav_pkg::ClCurly) begin
      // an open top-level curly counts as an other token
      fin_flags[bmav_pkg::FlOther] = 1'b1;
    end
    fin_key_blank = n.arg_many ? n.key_blank : ~fin_flags[bmav_pkg::FlAny];

    verdict_o = '{emit: 1'b0, ok: 1'b0, reason: bmav_pkg::RsnOk};
    if (fail) begin
      verdict_o = '{emit: 1'b1, ok: 1'b0, reason: fail_rsn};
    end else if (fin) begin
      if (!n.arg_many) begin
        verdict_o = '{emit: 1'b1, ok: 1'b0, reason: bmav_pkg::RsnFewArgs};
      end else if (fin_key_blank) begin
        verdict_o = '{emit: 1'b1, ok: 1'b0, reason: bmav_pkg::RsnEmptyKey};
      end else if (n.mixed ||
                   (fin_flags[bmav_pkg::FlBlock] && fin_flags[bmav_pkg::FlOther])) begin
        verdict_o = '{emit: 1'b1, ok: 1'b0, reason: bmav_pkg::RsnMixed};
      end else begin
        verdict_o = '{emit: 1'b1, ok: 1'b1, reason: bmav_pkg::RsnOk};
      end
    end

    st_o = verdict_o.emit ? bmav_pkg::StateReset : n;
  end

endmodule

// ===== sv/bracket_matched_argument_validator.sv =====
// ----------------------------------------------------------------------------
// bracket_matched_argument_validator: function argument list checker
// Checks the token stream after a function token for balanced brackets and
// the top-level argument grammar, one verdict per list.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one token per transaction, kind in s_axis_tdata[3:0],
//   s_axis_tlast marks the final token of the stream.
//   Master stream: one verdict per argument list, valid_res in bit 0 and
//   the reason code in bits 3:1 of m_axis_tdata.
//   Tokens that do not end or break the list give no transaction.
// Timing:
//   A token is taken into an input register, then decoded against the list
//   state in the next cycle; the state and the verdict register load at the
//   same edge, so a verdict passes the input and output registers. One token
//   per cycle while no verdict is held back by a stalled receiver: the state
//   update is a single decode plus one stack push or pop.
// Reset:
//   Clears the input and output stages and the list state; the closer stack
//   needs no clearing since only pushed entries are read.
// Stall:
//   A verdict held by a stalled receiver blocks only the next verdict-giving
//   token; other tokens keep flowing. Backpressure reaches s_axis_tready.
// ----------------------------------------------------------------------------
module bracket_matched_argument_validator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [3:0] kind, [7:4] zero
  input  logic       s_axis_tlast,   // last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] valid_res, [3:1] reason, [7:4] zero
);

  logic                  s1_valid_q;
  logic [3:0]            s1_kind_q;
  logic                  s1_last_q;
  bmav_pkg::list_state_t st_q;
  bmav_pkg::list_state_t st_d;
  logic [1:0]            stack_q [bmav_pkg::MaxNesting];
  logic [bmav_pkg::IdxW-1:0] top_idx;
  logic [bmav_pkg::IdxW-1:0] wr_idx;
  bmav_pkg::push_t       push;
  bmav_pkg::verdict_t    verdict;
  logic                  m_valid_q;
  logic                  m_ok_q;
  logic [2:0]            m_reason_q;
  logic                  out_free;
  logic                  fire;

  assign top_idx = bmav_pkg::IdxW'(st_q.depth - 1'b1);
  assign wr_idx  = bmav_pkg::IdxW'(st_q.depth);

  bmav_core u_core (
    .kind_i    (s1_kind_q),
    .last_i    (s1_last_q),
    .st_i      (st_q),
    .top_i     (stack_q[top_idx]),
    .bottom_i  (stack_q[0]),
    .st_o      (st_d),
    .push_o    (push),
    .verdict_o (verdict)
  );

  assign out_free      = !m_valid_q || m_axis_tready;
  assign fire          = s1_valid_q && (!verdict.emit || out_free);
  assign s_axis_tready = !s1_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
      st_q       <= bmav_pkg::StateReset;
    end else begin
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (fire) begin
        st_q <= st_d;
      end
      if (fire && verdict.emit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_kind_q <= s_axis_tdata[3:0];
      s1_last_q <= s_axis_tlast;
    end
    if (fire && push.en) begin
      stack_q[wr_idx] <= push.code;
    end
    if (fire && verdict.emit) begin
      m_ok_q     <= verdict.ok;
      m_reason_q <= verdict.reason;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0000, m_reason_q, m_ok_q};

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the bracket-matched argument validator
// Walks a table of directed tokens, then random argument lists, through the
// token stream. A local model of the list state predicts each verdict that
// the table does not give, and the result stream is checked in order.
// ----------------------------------------------------------------------------
module tb;
  import bmav_pkg::*;

  localparam logic [3:0] KindUnknownMax = 4'd15;  // 13..15 decode as other
  localparam int         TokenTarget    = 1050;
  localparam int         LongHold       = 200;
  localparam int         WatchLimit     = 3000;

  typedef struct packed {
    logic       ok;
    logic [2:0] reason;
  } verdict_rec_t;

  typedef struct packed {
    logic [3:0] kind;
    logic       last;
    logic [5:0] reps;
    logic       typed;    // ok/reason below are the expected verdict
    logic       ok;
    logic [2:0] reason;
  } stim_row_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = '0;
  logic       s_axis_tlast  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;

  always #10 clk_i = ~clk_i;

  bracket_matched_argument_validator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // list state of the predictor
  logic [1:0]  closer_mem [MaxNesting];
  int unsigned open_cnt   = 0;
  logic        comma_seen = 1'b0;
  logic        key_blank  = 1'b1;
  logic        mixed_hit  = 1'b0;
  logic [2:0]  arg_flags  = '0;

  verdict_rec_t verdict_q [$];
  logic [4:0]   token_q [$];   // {last, kind}

  int  tokens_sent  = 0;
  int  verdicts_got = 0;
  int  mismatches   = 0;
  int  reason_hits [8];
  bit  tx_burst     = 1'b0;
  bit  rx_burst     = 1'b0;
  bit  hold_req     = 1'b0;

  function automatic void clear_list();
    open_cnt   = 0;
    comma_seen = 1'b0;
    key_blank  = 1'b1;
    mixed_hit  = 1'b0;
    arg_flags  = '0;
  endfunction

  function automatic verdict_rec_t reject(input logic [2:0] why);
    verdict_rec_t v;
    clear_list();
    v.ok     = 1'b0;
    v.reason = why;
    return v;
  endfunction

  // end of list: open brackets count as closed
  function automatic verdict_rec_t close_list();
    logic [2:0] fl;
    fl = arg_flags;
    // a top-level '{' still open is just another token
    if (open_cnt > 0 && closer_mem[0] == ClCurly) fl[FlOther] = 1'b1;
    if (!comma_seen) return reject(RsnFewArgs);
    if (key_blank) return reject(RsnEmptyKey);
    if (mixed_hit || (fl[FlBlock] && fl[FlOther])) return reject(RsnMixed);
    clear_list();
    return '{ok: 1'b1, reason: RsnOk};
  endfunction

  function automatic bit judge_token(input logic [3:0] kind_in, input logic last,
                                     output verdict_rec_t v);
    logic [3:0] k;
    logic [1:0] code;
    k = (kind_in > KindRCurly) ? KindOther : kind_in;
    v = '0;
    if (k == KindEof) begin
      v = close_list();
      return 1'b1;
    end
    if (k >= KindRParen) begin
      code = 2'(k - KindRParen);
      if (open_cnt == 0) begin
        v = (code == ClParen) ? close_list() : reject(RsnUnmatched);
        return 1'b1;
      end
      if (closer_mem[open_cnt-1] != code) begin
        v = reject(RsnUnmatched);
        return 1'b1;
      end
      open_cnt--;
      if (open_cnt == 0 && code == ClCurly) arg_flags[FlBlock] = 1'b1;
    end else if (open_cnt == 0 && k == KindComma) begin
      if (!comma_seen) key_blank = !arg_flags[FlAny];
      mixed_hit  = mixed_hit | (arg_flags[FlBlock] & arg_flags[FlOther]);
      comma_seen = 1'b1;
      arg_flags  = '0;
    end else if (open_cnt == 0 && k == KindSemi) begin
      v = reject(RsnSemicolon);
      return 1'b1;
    end else if (open_cnt == 0 && k == KindBang) begin
      v = reject(RsnBang);
      return 1'b1;
    end else if (k != KindSpace) begin
      if (open_cnt == 0) begin
        arg_flags[FlAny] = 1'b1;
        if (k != KindLCurly) arg_flags[FlOther] = 1'b1;
      end
      if (k >= KindFunc) begin
        if (open_cnt >= MaxNesting) begin
          v = reject(RsnTooDeep);
          return 1'b1;
        end
        closer_mem[open_cnt] = (k == KindLSquare) ? ClSquare :
                               (k == KindLCurly)  ? ClCurly  : ClParen;
        open_cnt++;
      end
    end
    if (last) begin
      v = close_list();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // one token transaction; the prediction is taken at the accepting edge
  task automatic offer_token(input logic [3:0] kind, input logic last,
                             input bit typed, input verdict_rec_t typed_v);
    verdict_rec_t v;
    bit           fire;
    int           gap;
    gap = tx_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, kind};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    tokens_sent++;
    fire = judge_token(kind, last, v);
    if (typed) begin
      fire = 1'b1;
      v    = typed_v;
    end
    if (fire) verdict_q.insert(verdict_q.size(), v);
  endtask

  task automatic drain_verdicts();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (verdict_q.size() != 0);
  endtask

  function automatic stim_row_t row(input logic [3:0] kind, input logic last,
                                    input int reps, input bit typed,
                                    input logic ok, input logic [2:0] reason);
    stim_row_t r;
    r.kind   = kind;
    r.last   = last;
    r.reps   = 6'(reps);
    r.typed  = typed;
    r.ok     = ok;
    r.reason = reason;
    return r;
  endfunction

  function automatic void queue_tok(input logic [3:0] kind, input logic last);
    token_q.insert(token_q.size(), {last, kind});
  endfunction

  function automatic logic [3:0] filler_kind();
    case ($urandom_range(0, 5))
      0:       return KindOther;
      1:       return KindSpace;
      2:       return KindComma;
      3:       return KindSemi;
      4:       return KindBang;
      default: return 4'($urandom_range(KindRCurly + 1, KindUnknownMax));
    endcase
  endfunction

  // balanced bracket group, openers pushed then closed in reverse
  function automatic void gen_group(input int depth);
    logic [3:0] openers [$];
    logic [3:0] op;
    for (int i = 0; i < depth; i++) begin
      case ($urandom_range(0, 3))
        0:       op = KindFunc;
        1:       op = KindLParen;
        2:       op = KindLSquare;
        default: op = KindLCurly;
      endcase
      openers.insert(openers.size(), op);
      queue_tok(op, 1'b0);
      if ($urandom_range(0, 3) == 0) queue_tok(filler_kind(), 1'b0);
    end
    while (openers.size() > 0) begin
      op = openers[openers.size() - 1];
      openers.delete(openers.size() - 1);
      case (op)
        KindLSquare: queue_tok(KindRSquare, 1'b0);
        KindLCurly:  queue_tok(KindRCurly, 1'b0);
        default:     queue_tok(KindRParen, 1'b0);
      endcase
      if ($urandom_range(0, 4) == 0) queue_tok(filler_kind(), 1'b0);
    end
  endfunction

  // one argument list, mostly well formed, sometimes with a broken token
  function automatic void gen_list();
    int nargs;
    int ntok;
    int choice;
    int idx;
    nargs = $urandom_range(0, 4);
    for (int a = 0; a < nargs; a++) begin
      if (a > 0) queue_tok(KindComma, 1'b0);
      ntok = $urandom_range(0, 3);
      for (int t = 0; t < ntok; t++) begin
        choice = $urandom_range(0, 99);
        if (choice < 35) begin
          queue_tok(($urandom_range(0, 3) == 0) ?
                    4'($urandom_range(KindRCurly + 1, KindUnknownMax)) : KindOther, 1'b0);
        end else if (choice < 50) begin
          queue_tok(KindSpace, 1'b0);
        end else if (choice < 65) begin
          queue_tok(KindLCurly, 1'b0);
          if ($urandom_range(0, 1) == 0) queue_tok(KindOther, 1'b0);
          queue_tok(KindRCurly, 1'b0);
        end else if (choice < 99) begin
          gen_group($urandom_range(1, 3));
        end else begin
          gen_group($urandom_range(MaxNesting - 2, MaxNesting + 1));
        end
      end
    end
    choice = $urandom_range(0, 99);
    if (choice < 55) queue_tok(KindRParen, 1'b0);
    else if (choice < 75) queue_tok(KindEof, 1'b0);
    else if (token_q.size() == 0) queue_tok(KindOther, 1'b1);
    else token_q[token_q.size()-1][4] = 1'b1;
    if ($urandom_range(0, 9) == 0) begin
      idx = $urandom_range(0, token_q.size() - 1);
      token_q[idx][3:0] = 4'($urandom_range(0, KindUnknownMax));
    end
    if ($urandom_range(0, 19) == 0) begin
      idx = $urandom_range(0, token_q.size() - 1);
      token_q[idx][4] = 1'b1;
    end
  endfunction

  // result side: per-verdict stall, one long hold on request
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        hold_req = 1'b0;
      end
      stall = rx_burst ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    verdict_rec_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      verdicts_got++;
      reason_hits[m_axis_tdata[3:1]]++;
      if (verdict_q.size() == 0) begin
        report_mismatch("verdict with none pending", m_axis_tdata, -1);
      end else begin
        want = verdict_q.pop_front();
        if (m_axis_tdata[0] !== want.ok)
          report_mismatch("valid_res", m_axis_tdata[0], want.ok);
        if (m_axis_tdata[3:1] !== want.reason)
          report_mismatch("reason", m_axis_tdata[3:1], want.reason);
        if (m_axis_tdata[7:4] !== 4'b0000)
          report_mismatch("tdata pad", m_axis_tdata[7:4], 0);
      end
    end
  end

  // watchdog: cycles without any transaction on either side
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WatchLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout after %0d idle cycles, %0d verdicts pending",
             WatchLimit, verdict_q.size());
    $display("FAIL");
    $finish;
  end

  initial begin
    stim_row_t    plan [$];
    verdict_rec_t tv;
    logic [4:0]   tk;
    int           directed_cnt;
    bit           hold_done;
    bit           drain_done;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    foreach (reason_hits[i]) reason_hits[i] = 0;

    plan = {plan, row(KindRSquare, 1'b0, 1, 1'b1, 1'b0, RsnUnmatched)};
    plan = {plan, row(KindRCurly,  1'b0, 1, 1'b1, 1'b0, RsnUnmatched)};
    plan = {plan, row(KindRParen,  1'b0, 1, 1'b1, 1'b0, RsnFewArgs)};
    plan = {plan, row(KindComma,   1'b0, 1, 1'b0, 1'b0, RsnOk)};
    plan = {plan, row(KindRParen,  1'b0, 1, 1'b1, 1'b0, RsnEmptyKey)};
    plan = {plan, row(KindOther,   1'b0, 1, 1'b0, 1'b0, RsnOk)};
    plan = {plan, row(KindComma,   1'b0, 1, 1'b0, 1'b0, RsnOk)};
    plan = {plan, row(KindFunc,    1'b0, 1, 1'b0, 1'b0, RsnOk)};
    plan = {plan, row(KindRParen,  1'b0, 1, 1'b0, 1'b0, RsnOk)};
    plan = {plan, row(KindRParen,  1'b0, 1, 1'b1, 1'b1, RsnOk)};
    plan = {plan, row(KindSemi,    1'b0, 1, 1'b1, 1'b0, RsnSemicolon)};
    plan = {plan, row(KindBang,    1'b0, 1, 1'b1, 1'b0, RsnBang)};
    // block and other token in the key
    plan = {plan, row(KindLCurly,  1'b0, 1, 1'b0, 1'b0, RsnOk)};
    plan = {plan, row(KindRCurly,  1'b0, 1, 1'b0, 1'b0, RsnOk)};
    plan = {plan, row(KindUnknownMax, 1'b0, 1, 1'b0, 1'b0, RsnOk)};
    plan = {plan, row(KindComma,   1'b0, 1, 1'b0, 1'b0, RsnOk)};
    plan = {plan, row(KindEof,     1'b0, 1, 1'b1, 1'b0, RsnMixed)};
    // full stack, then one opener too many
    plan = {plan, row(KindLParen,  1'b0, MaxNesting, 1'b0, 1'b0, RsnOk)};
    plan = {plan, row(KindLSquare, 1'b0, 1, 1'b1, 1'b0, RsnTooDeep)};
    // full stack unwound, then a second argument left open at the end
    plan = {plan, row(KindLSquare, 1'b0, MaxNesting, 1'b0, 1'b0, RsnOk)};
    plan = {plan, row(KindRSquare, 1'b0, MaxNesting, 1'b0, 1'b0, RsnOk)};
    plan = {plan, row(KindComma,   1'b0, 1, 1'b0, 1'b0, RsnOk)};
    plan = {plan, row(KindLCurly,  1'b0, 1, 1'b0, 1'b0, RsnOk)};
    plan = {plan, row(KindSemi,    1'b0, 1, 1'b0, 1'b0, RsnOk)};
    plan = {plan, row(KindSpace,   1'b1, 1, 1'b0, 1'b0, RsnOk)};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      for (int r = 0; r < plan[i].reps; r++) begin
        tv.ok     = plan[i].ok;
        tv.reason = plan[i].reason;
        offer_token(plan[i].kind, plan[i].last,
                    plan[i].typed && (r == plan[i].reps - 1), tv);
      end
    end
    directed_cnt = tokens_sent;

    tv = '0;
    while (tokens_sent < TokenTarget) begin
      if (!hold_done && tokens_sent >= 400) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && tokens_sent >= 700) begin
        drain_verdicts();
        drain_done = 1'b1;
      end
      tx_burst = ($urandom_range(0, 4) == 0);
      gen_list();
      while (token_q.size() > 0) begin
        tk = token_q.pop_front();
        offer_token(tk[3:0], tk[4], 1'b0, tv);
      end
    end

    drain_verdicts();
    repeat (8) @(posedge clk_i);

    $display("covered %0d tokens (%0d from the directed table), %0d verdicts checked",
             tokens_sent, directed_cnt, verdicts_got);
    $display({"verdicts by reason ok/unm/semi/bang/few/key/mix/deep: ",
              "%0d %0d %0d %0d %0d %0d %0d %0d"},
             reason_hits[0], reason_hits[1], reason_hits[2], reason_hits[3],
             reason_hits[4], reason_hits[5], reason_hits[6], reason_hits[7]);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
